// File: rtl/core/msme_pkg.sv
// Shared character codes for the math-span markup escaper.
package msme_pkg;

  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChLBracket  = 8'h5B;
  localparam logic [7:0] ChRBracket  = 8'h5D;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChUnderline = 8'h5F;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChLineFeed  = 8'h0A;

  // Input kinds carried on tuser.
  localparam logic KindChar = 1'b0;
  localparam logic KindEol  = 1'b1;

  // Longest burst of output bytes that a single input transaction can cause.
  localparam int unsigned MaxBurst = 4;

endpackage

// File: rtl/core/math_span_markup_escaper_top.sv
// Math-span markup escaper: look-ahead byte, math mode tracking and output burst buffer.
// The first output byte of an input transaction that yields bytes is presented the cycle after it.
// Throughput: one input transaction per cycle while each yields at most one byte and the
// output is not stalled; a transaction that yields more (at most four) holds the buffer until its last byte leaves.
// Reset (rst_ni low, asynchronous): both math modes clear, nothing is held, the next byte
// is taken as the start of a line, and the output burst buffer is emptied.
module math_span_markup_escaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  logic       s_axis_tuser_i,   // [0] item_kind (0 = character, 1 = end of line)
  // Output stream.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last_of_run
);

  // Escaper state. The byte held back is only resolved once the next item is seen,
  // because a '$' may turn out to be the first half of a "$$" delimiter.
  logic       disp_q, disp_d;
  logic       inl_q, inl_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       line_start_q, line_start_d;
  logic       prior_bs_q, prior_bs_d;

  // Output burst buffer: the bytes for one input transaction, drained from the head.
  logic [7:0] buf_q [msme_pkg::MaxBurst];
  logic [7:0] bb    [msme_pkg::MaxBurst];
  logic [1:0] rem_q;
  logic       out_vld_q;

  logic       s_acc;
  logic       m_beat;

  // Held-byte resolution results.
  logic [7:0] pb [3];
  logic [1:0] pn;
  logic       consumed;
  logic       p_disp, p_inl;
  logic       esc, pair, single, nxt_dollar;
  logic [2:0] bn;

  assign m_beat          = out_vld_q & m_axis_tready_i;
  // A new transaction may enter as soon as the buffer is empty or its last byte leaves.
  assign s_axis_tready_o = ~out_vld_q | (m_axis_tready_i & (rem_q == 2'd0));
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = buf_q[0];
  assign m_axis_tlast_o  = (rem_q == 2'd0);

  // Decide what the held byte turns into. Only a character item offers a look-ahead byte;
  // at end of line a lone '$' is an inline delimiter unless escaped or inside display math.
  always_comb begin
    nxt_dollar = (s_axis_tuser_i == msme_pkg::KindChar) &&
                 (s_axis_tdata_i == msme_pkg::ChDollar);
    esc        = ~line_start_q & prior_bs_q;
    pair       = (held_q == msme_pkg::ChDollar) && nxt_dollar && !esc;
    single     = (held_q == msme_pkg::ChDollar) && !nxt_dollar && !esc;

    pb[0]    = held_q;
    pb[1]    = msme_pkg::ChSpace;
    pb[2]    = msme_pkg::ChSpace;
    pn       = 2'd1;
    consumed = 1'b0;
    p_disp   = disp_q;
    p_inl    = inl_q;

    if (!disp_q && !inl_q) begin
      if (pair) begin
        // Display math opener.
        pb[0]    = msme_pkg::ChDollar;
        pb[1]    = msme_pkg::ChDollar;
        pn       = 2'd3;
        p_disp   = 1'b1;
        consumed = 1'b1;
      end else if (single) begin
        // Inline math opener.
        pb[0] = msme_pkg::ChDollar;
        pn    = 2'd2;
        p_inl = 1'b1;
      end
    end else if (disp_q && pair) begin
      // Display math closer.
      pb[1]    = msme_pkg::ChDollar;
      pb[2]    = msme_pkg::ChDollar;
      pb[0]    = msme_pkg::ChSpace;
      pn       = 2'd3;
      p_disp   = 1'b0;
      consumed = 1'b1;
    end else if (inl_q && single) begin
      // Inline math closer.
      pb[0] = msme_pkg::ChSpace;
      pb[1] = msme_pkg::ChDollar;
      pn    = 2'd2;
      p_inl = 1'b0;
    end else if (held_q inside {msme_pkg::ChStar, msme_pkg::ChLBracket, msme_pkg::ChRBracket,
                                msme_pkg::ChLParen, msme_pkg::ChRParen}) begin
      pb[0] = msme_pkg::ChBackslash;
      pb[1] = held_q;
      pn    = 2'd2;
    end else if (held_q inside {msme_pkg::ChUnderline, msme_pkg::ChCaret}) begin
      pb[0] = msme_pkg::ChSpace;
      pb[1] = held_q;
      pn    = 2'd3;
    end else if (held_q == msme_pkg::ChDollar) begin
      // An escaped dollar, or one that is neither opener nor closer here.
      pn = 2'd2;
    end
  end

  // Next state and the burst that one accepted transaction produces.
  always_comb begin
    disp_d       = disp_q;
    inl_d        = inl_q;
    held_d       = held_q;
    held_vld_d   = held_vld_q;
    line_start_d = line_start_q;
    prior_bs_d   = prior_bs_q;
    bb[0]        = pb[0];
    bb[1]        = pb[1];
    bb[2]        = pb[2];
    bb[3]        = msme_pkg::ChLineFeed;
    bn           = 3'd0;

    if (s_axis_tuser_i == msme_pkg::KindChar) begin
      if (!held_vld_q) begin
        // Nothing held yet: this byte only becomes the look-ahead byte.
        held_d     = s_axis_tdata_i;
        held_vld_d = 1'b1;
      end else begin
        bn    = {1'b0, pn};
        disp_d = p_disp;
        inl_d  = p_inl;
        line_start_d = 1'b0;
        if (consumed) begin
          // The incoming '$' was the second half of a pair and is used up.
          held_vld_d = 1'b0;
          prior_bs_d = 1'b0;
        end else begin
          prior_bs_d = (held_q == msme_pkg::ChBackslash);
          held_d     = s_axis_tdata_i;
        end
      end
    end else begin
      // End of line: flush whatever is held, then line feed.
      if (held_vld_q) begin
        disp_d = p_disp;
        inl_d  = p_inl;
        bn     = 3'({1'b0, pn} + 3'd1);
        case (pn)
          2'd1:    bb[1] = msme_pkg::ChLineFeed;
          2'd2:    bb[2] = msme_pkg::ChLineFeed;
          default: bb[3] = msme_pkg::ChLineFeed;
        endcase
      end else begin
        bb[0] = msme_pkg::ChLineFeed;
        bn    = 3'd1;
      end
      held_vld_d   = 1'b0;
      line_start_d = 1'b1;
      prior_bs_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q       <= 1'b0;
      inl_q        <= 1'b0;
      held_q       <= 8'h00;
      held_vld_q   <= 1'b0;
      line_start_q <= 1'b1;
      prior_bs_q   <= 1'b0;
      rem_q        <= 2'd0;
      out_vld_q    <= 1'b0;
    end else begin
      // A new burst is only loaded when the buffer is empty or its last byte is leaving.
      if (s_acc && (bn != 3'd0)) begin
        out_vld_q <= 1'b1;
        rem_q     <= 2'(bn - 3'd1);
      end else if (m_beat) begin
        if (rem_q == 2'd0) begin
          out_vld_q <= 1'b0;
        end else begin
          rem_q <= rem_q - 2'd1;
        end
      end
      if (s_acc) begin
        disp_q       <= disp_d;
        inl_q        <= inl_d;
        held_q       <= held_d;
        held_vld_q   <= held_vld_d;
        line_start_q <= line_start_d;
        prior_bs_q   <= prior_bs_d;
      end
    end
  end

  // Burst payload: loaded on a transaction that yields bytes, shifted towards the head
  // on every output transaction.
  always_ff @(posedge clk_i) begin
    if (s_acc && (bn != 3'd0)) begin
      buf_q <= bb;
    end else if (m_beat) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
      buf_q[2] <= buf_q[3];
    end
  end

endmodule

// File: rtl/core/msme_checker.sv
// Port-level checker for the math-span markup escaper, with its bind statement.
module msme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // A stalled output transaction keeps its byte and its end marker.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // Nothing is offered on the output while reset is asserted.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // With no burst pending the block always takes input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // An end of line accepted while the output is empty yields at least its line feed on the next cycle.
  a_eol_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == msme_pkg::KindEol) &&
      !m_axis_tvalid_o |=> m_axis_tvalid_o)
    else $error("end of line produced no output");

endmodule

bind math_span_markup_escaper_top msme_checker u_msme_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
